// File: rtl/core/planar_body_euler_step_macros.svh
// Assertion helpers shared by the checker files of this block.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef PLANAR_BODY_EULER_STEP_MACROS_SVH
`define PLANAR_BODY_EULER_STEP_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define PEBS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that must be followed in the next cycle by a consequence.
`define PEBS_ASSERT_NEXT(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/pebs_pkg.sv
package pebs_pkg;

	localparam int DATA_W        = 32;
	localparam int MASS_W        = 32;
	localparam int DRAG_W        = 24;
	localparam int LIMIT_W       = 31;
	localparam int DT_W          = 24;
	localparam int FRAC_BITS_DEF = 16;
	// Signed product of a 32-bit value and a 24-bit unsigned value.
	localparam int PROD_W        = DATA_W + DRAG_W + 1;
	// Room for sums of a 32-bit value and a shifted product.
	localparam int WIDE_W        = PROD_W + 1;
	localparam int IDX_W         = 3;

	localparam logic [IDX_W-1:0] REG_PHYSICS_ON  = 3'd0;
	localparam logic [IDX_W-1:0] REG_DRAG_ON     = 3'd1;
	localparam logic [IDX_W-1:0] REG_BODY_MASS   = 3'd2;
	localparam logic [IDX_W-1:0] REG_DRAG_FACTOR = 3'd3;
	localparam logic [IDX_W-1:0] REG_SPEED_LIMIT = 3'd4;
	localparam logic [IDX_W-1:0] REG_START_X     = 3'd5;
	localparam logic [IDX_W-1:0] REG_START_Y     = 3'd6;

	typedef struct packed {
		logic signed [DATA_W-1:0] force_x;
		logic signed [DATA_W-1:0] force_y;
		logic [DT_W-1:0]          time_step;
	} in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] pos_x;
		logic signed [DATA_W-1:0] pos_y;
		logic signed [DATA_W-1:0] vel_x;
		logic signed [DATA_W-1:0] vel_y;
	} out_t;

	typedef struct packed {
		logic               physics_on;
		logic               drag_on;
		logic [MASS_W-1:0]  body_mass;
		logic [DRAG_W-1:0]  drag_factor;
		logic [LIMIT_W-1:0] speed_limit;
	} lane_ctrl_t;

	typedef struct packed {
		logic                     done;
		logic signed [DATA_W-1:0] pos;
		logic signed [DATA_W-1:0] vel;
	} lane_stat_t;

	// Saturate a wide signed value to the signed 32-bit range.
	function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [WIDE_W-1:0] v);
		logic [WIDE_W-DATA_W:0] upper;
		upper = v[WIDE_W-1:DATA_W-1];
		if ((&upper) || !(|upper)) begin
			return v[DATA_W-1:0];
		end else if (v[WIDE_W-1]) begin
			return {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			return {1'b0, {(DATA_W-1){1'b1}}};
		end
	endfunction

endpackage

// File: rtl/core/pebs_div.sv
module pebs_div #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	logic [DEN_W:0] shifted;
	logic [DEN_W:0] diff;
	logic           fits;

	// Restoring division, one quotient bit per cycle.
	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = (shifted >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			den_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q <= '0;
				den_q <= den;
				quo_q <= num;
				cnt_q <= CNT_W'(NUM_W);
				run_q <= 1'b1;
			end else if (run_q) begin
				rem_q <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// File: rtl/core/pebs_lane.sv
module pebs_lane #(
	parameter int FRAC_BITS = pebs_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  pebs_pkg::lane_ctrl_t                  ctrl,
	input  logic                                  start,
	input  logic signed [pebs_pkg::DATA_W-1:0]    force_in,
	input  logic [pebs_pkg::DT_W-1:0]             dt_in,
	input  logic                                  load_pos,
	input  logic signed [pebs_pkg::DATA_W-1:0]    load_val,
	output pebs_pkg::lane_stat_t                  stat
);

	localparam int DW    = pebs_pkg::DATA_W;
	localparam int PW    = pebs_pkg::PROD_W;
	localparam int WW    = pebs_pkg::WIDE_W;
	localparam int NUM_W = DW + FRAC_BITS;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DRAG = 3'd1;
	localparam logic [2:0] ST_NET  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_WAIT = 3'd4;
	localparam logic [2:0] ST_STEP = 3'd5;
	localparam logic [2:0] ST_NV   = 3'd6;
	localparam logic [2:0] ST_UPD  = 3'd7;

	logic [2:0]                     state_q;
	logic                           done_q;
	logic signed [DW-1:0]           pos_q;
	logic signed [DW-1:0]           vel_q;
	logic signed [DW-1:0]           pend_q;
	logic signed [DW-1:0]           force_q;
	logic [pebs_pkg::DT_W-1:0]      dt_q;
	logic signed [PW-1:0]           drag_prod_q;
	logic signed [DW-1:0]           net_q;
	logic signed [DW-1:0]           accel_q;
	logic signed [PW-1:0]           step_prod_q;
	logic signed [DW-1:0]           nv_q;

	logic signed [DW-1:0]           pend_sum;
	logic signed [PW-1:0]           drag_shift;
	logic signed [WW-1:0]           net_wide;
	logic [DW-1:0]                  net_u;
	logic [DW-1:0]                  net_mag;
	logic [NUM_W-1:0]               div_num;
	logic [pebs_pkg::MASS_W-1:0]    div_den;
	logic                           div_start;
	logic                           div_done;
	logic [NUM_W-1:0]               div_quot;
	logic signed [DW-1:0]           accel_sat;
	logic signed [PW-1:0]           step_shift;
	logic signed [DW-1:0]           lim_p;
	logic signed [DW-1:0]           lim_n;

	assign pend_sum   = pebs_pkg::sat_data(WW'(pend_q) + WW'(force_in));
	assign drag_shift = drag_prod_q >>> FRAC_BITS;
	assign net_wide   = WW'(pend_q) + WW'(force_q)
		- (ctrl.drag_on ? WW'(drag_shift) : {WW{1'b0}});

	// Divide the magnitude and put the sign back, which truncates toward zero.
	assign net_u     = net_q;
	assign net_mag   = net_u[DW-1] ? (~net_u + {{(DW-1){1'b0}}, 1'b1}) : net_u;
	assign div_num   = {net_mag, {FRAC_BITS{1'b0}}};
	assign div_den   = (ctrl.body_mass == '0) ? pebs_pkg::MASS_W'(1) : ctrl.body_mass;
	assign div_start = (state_q == ST_DIV);

	pebs_div #(
		.NUM_W(NUM_W),
		.DEN_W(pebs_pkg::MASS_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_comb begin
		if (!net_q[DW-1]) begin
			if (|div_quot[NUM_W-1:DW-1]) begin
				accel_sat = {1'b0, {(DW-1){1'b1}}};
			end else begin
				accel_sat = div_quot[DW-1:0];
			end
		end else begin
			if ((|div_quot[NUM_W-1:DW]) || (div_quot[DW-1] && (|div_quot[DW-2:0]))) begin
				accel_sat = {1'b1, {(DW-1){1'b0}}};
			end else begin
				accel_sat = ~div_quot[DW-1:0] + {{(DW-1){1'b0}}, 1'b1};
			end
		end
	end

	assign step_shift = step_prod_q >>> FRAC_BITS;
	assign lim_p      = $signed({1'b0, ctrl.speed_limit});
	assign lim_n      = -lim_p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			done_q      <= 1'b0;
			pos_q       <= '0;
			vel_q       <= '0;
			pend_q      <= '0;
			force_q     <= '0;
			dt_q        <= '0;
			drag_prod_q <= '0;
			net_q       <= '0;
			accel_q     <= '0;
			step_prod_q <= '0;
			nv_q        <= '0;
		end else begin
			done_q <= 1'b0;
			if (load_pos) begin
				pos_q <= load_val;
			end
			case (state_q)
				ST_IDLE: begin
					if (start && !ctrl.physics_on) begin
						pend_q <= pend_sum;
						done_q <= 1'b1;
					end else if (start) begin
						force_q <= force_in;
						dt_q    <= dt_in;
						state_q <= ST_DRAG;
					end
				end
				ST_DRAG: begin
					drag_prod_q <= $signed({1'b0, ctrl.drag_factor}) * vel_q;
					state_q     <= ST_NET;
				end
				ST_NET: begin
					net_q   <= pebs_pkg::sat_data(net_wide);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_done) begin
						accel_q <= accel_sat;
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					step_prod_q <= accel_q * $signed({1'b0, dt_q});
					state_q     <= ST_NV;
				end
				ST_NV: begin
					nv_q    <= pebs_pkg::sat_data(WW'(vel_q) + WW'(step_shift));
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					pos_q <= pebs_pkg::sat_data(WW'(pos_q) + WW'(nv_q));
					if (nv_q > lim_p) begin
						vel_q <= lim_p;
					end else if (nv_q < lim_n) begin
						vel_q <= lim_n;
					end else begin
						vel_q <= nv_q;
					end
					pend_q  <= '0;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign stat.done = done_q;
	assign stat.pos  = pos_q;
	assign stat.vel  = vel_q;

endmodule

// File: rtl/core/planar_body_euler_step.sv
// One explicit Euler step of a point body in the plane for every input beat while physics is on.
// The input channel (in_valid, in_ready, in_data) carries a force (x, y) and a
// time step. The output channel (out_valid, out_ready, out_data) returns one
// beat per input beat with the position and clamped velocity after the step.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// the registers; it is always ready and must only be used while the block is
// idle. Writing start_x or start_y also moves the body to that position.
// Two identical lanes, one per axis, run side by side; a merge stage waits for
// both and loads the output register.
// With physics on, an accepted beat passes the lane states drag, net, divide,
// wait, step, new velocity and update on its way to the output; the divider in
// each lane is bit-serial and makes one quotient bit per cycle. With physics
// off the force only adds to the pending sum and the result goes through the
// lane and merge done flags to the output register. One beat is in flight at a
// time: in_ready drops at acceptance and rises again once the result sits in
// the output register, so a stalled receiver holds back at most one further beat.
// Reset clears the body to position zero, zero velocity and zero pending
// force, and sets the registers to their reset values.
module planar_body_euler_step #(
	parameter int FRAC_BITS = pebs_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  pebs_pkg::in_t                 in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output pebs_pkg::out_t                out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pebs_pkg::IDX_W-1:0]    cfg_index,
	input  logic [pebs_pkg::DATA_W-1:0]   cfg_data
);

	localparam logic [pebs_pkg::MASS_W-1:0] MASS_RESET =
		pebs_pkg::MASS_W'(64'd1 << FRAC_BITS);
	localparam logic [pebs_pkg::LIMIT_W-1:0] LIMIT_RESET =
		pebs_pkg::LIMIT_W'(64'd15 << FRAC_BITS);

	// Configuration registers, gathered into the control group of the lanes.
	pebs_pkg::lane_ctrl_t ctrl_q;

	logic busy_q;
	logic done_x_q;
	logic done_y_q;
	logic out_valid_q;
	pebs_pkg::out_t out_q;

	logic in_fire;
	logic load_x;
	logic load_y;
	logic merge;
	pebs_pkg::lane_stat_t stat_x;
	pebs_pkg::lane_stat_t stat_y;

	assign cfg_ready = 1'b1;
	assign in_ready  = !busy_q;
	assign in_fire   = in_valid && in_ready;
	assign load_x    = cfg_valid && (cfg_index == pebs_pkg::REG_START_X);
	assign load_y    = cfg_valid && (cfg_index == pebs_pkg::REG_START_Y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q.physics_on  <= 1'b0;
			ctrl_q.drag_on     <= 1'b0;
			ctrl_q.body_mass   <= MASS_RESET;
			ctrl_q.drag_factor <= '0;
			ctrl_q.speed_limit <= LIMIT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				pebs_pkg::REG_PHYSICS_ON:  ctrl_q.physics_on  <= cfg_data[0];
				pebs_pkg::REG_DRAG_ON:     ctrl_q.drag_on     <= cfg_data[0];
				pebs_pkg::REG_BODY_MASS:   ctrl_q.body_mass   <= cfg_data;
				pebs_pkg::REG_DRAG_FACTOR: ctrl_q.drag_factor <= cfg_data[pebs_pkg::DRAG_W-1:0];
				pebs_pkg::REG_SPEED_LIMIT: ctrl_q.speed_limit <= cfg_data[pebs_pkg::LIMIT_W-1:0];
				default: begin
					// Start positions go straight to the lanes; other indexes are ignored.
				end
			endcase
		end
	end

	pebs_lane #(
		.FRAC_BITS(FRAC_BITS)
	) u_lane_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl_q),
		.start   (in_fire),
		.force_in(in_data.force_x),
		.dt_in   (in_data.time_step),
		.load_pos(load_x),
		.load_val($signed(cfg_data)),
		.stat    (stat_x)
	);

	pebs_lane #(
		.FRAC_BITS(FRAC_BITS)
	) u_lane_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl_q),
		.start   (in_fire),
		.force_in(in_data.force_y),
		.dt_in   (in_data.time_step),
		.load_pos(load_y),
		.load_val($signed(cfg_data)),
		.stat    (stat_y)
	);

	// The merge stage fires once both lanes have finished and the output
	// register is free or being emptied in this cycle. The lanes hold their
	// state until then, because no new beat is taken while busy.
	assign merge = done_x_q && done_y_q && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			done_x_q    <= 1'b0;
			done_y_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				busy_q <= 1'b1;
			end
			if (stat_x.done) begin
				done_x_q <= 1'b1;
			end
			if (stat_y.done) begin
				done_y_q <= 1'b1;
			end
			if (merge) begin
				busy_q      <= 1'b0;
				done_x_q    <= 1'b0;
				done_y_q    <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (merge) begin
			out_q.pos_x <= stat_x.pos;
			out_q.pos_y <= stat_y.pos;
			out_q.vel_x <= stat_x.vel;
			out_q.vel_y <= stat_y.vel;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: rtl/core/pebs_checker.sv
`include "planar_body_euler_step_macros.svh"

module pebs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input pebs_pkg::out_t                out_data
);

	// Only one beat is in flight: acceptance closes the input side.
	`PEBS_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second beat taken while busy")

	// A new result only appears after the input side was closed by a beat.
	`PEBS_ASSERT(a_result_has_cause, $rose(out_valid) |-> $past(!in_ready), "result without a beat")

	// No result can be ready in the cycle right after acceptance.
	`PEBS_ASSERT_NEXT(a_min_latency, in_valid && in_ready, !$rose(out_valid), "result too early")

	// A stalled result keeps its payload until it is taken.
	`PEBS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind planar_body_euler_step pebs_checker u_pebs_checker (.*);

// File: tb/euler_step_checker.sv
`timescale 1ns / 1ps

// Watches the three channels of the Euler step block. It keeps its own copy of the
// registers and of the body, predicts the result of every accepted tick and compares
// each result beat with the oldest prediction.
module euler_step_checker
	import pebs_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  in_t               in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  out_t              out_data,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	output int                fail_count,
	output int                beats_waiting
);

	localparam longint WORD_MAX = 64'sd2147483647;
	localparam longint WORD_MIN = -64'sd2147483648;
	localparam logic [MASS_W-1:0]  MASS_RESET  = MASS_W'(64'd1 << FRAC_BITS);
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64'd15 << FRAC_BITS);

	logic                     physics_on_q;
	logic                     drag_on_q;
	logic [MASS_W-1:0]        mass_q;
	logic [DRAG_W-1:0]        drag_q;
	logic [LIMIT_W-1:0]       limit_q;
	logic signed [DATA_W-1:0] pos_q [2];
	logic signed [DATA_W-1:0] vel_q [2];
	logic signed [DATA_W-1:0] force_sum [2];

	out_t predicted_states [$];
	out_t want;
	int   errors = 0;
	int   results_seen = 0;

	assign fail_count = errors;

	function automatic logic signed [DATA_W-1:0] clip_word(input longint v);
		if (v > WORD_MAX) begin
			v = WORD_MAX;
		end else if (v < WORD_MIN) begin
			v = WORD_MIN;
		end
		return v[DATA_W-1:0];
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic check_field(input string field, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] exp_val);
		if (got !== exp_val) begin
			report_mismatch($sformatf("result %0d %s: got %h, predicted %h",
				results_seen, field, got, exp_val));
		end
	endtask

	// One Euler step on one axis. Products are floored, the division truncates.
	task automatic advance_axis(input int axis, input logic signed [DATA_W-1:0] push,
			input logic [DT_W-1:0] dt);
		longint net_force;
		longint divisor;
		longint accel;
		longint speed;
		longint cap;
		net_force = longint'(force_sum[axis]) + longint'(push);
		if (drag_on_q) begin
			net_force -= (longint'(drag_q) * longint'(vel_q[axis])) >>> FRAC_BITS;
		end
		net_force = longint'(clip_word(net_force));
		divisor = (mass_q == '0) ? 64'sd1 : longint'(mass_q);
		accel = longint'(clip_word((net_force <<< FRAC_BITS) / divisor));
		speed = longint'(clip_word(longint'(vel_q[axis])
			+ ((accel * longint'(dt)) >>> FRAC_BITS)));
		// Position moves by the velocity before the cap is applied.
		pos_q[axis] = clip_word(longint'(pos_q[axis]) + speed);
		cap = longint'(limit_q);
		if (speed > cap) begin
			speed = cap;
		end else if (speed < -cap) begin
			speed = -cap;
		end
		vel_q[axis] = speed[DATA_W-1:0];
		force_sum[axis] = '0;
	endtask

	task automatic apply_tick(input in_t beat);
		logic signed [DATA_W-1:0] push [2];
		out_t result;
		push[0] = beat.force_x;
		push[1] = beat.force_y;
		for (int axis = 0; axis < 2; axis++) begin
			if (physics_on_q) begin
				advance_axis(axis, push[axis], beat.time_step);
			end else begin
				force_sum[axis] = clip_word(longint'(force_sum[axis]) + longint'(push[axis]));
			end
		end
		result.pos_x = pos_q[0];
		result.pos_y = pos_q[1];
		result.vel_x = vel_q[0];
		result.vel_y = vel_q[1];
		predicted_states.push_back(result);
	endtask

	task automatic apply_setting(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		case (idx)
			REG_PHYSICS_ON:  physics_on_q = data[0];
			REG_DRAG_ON:     drag_on_q = data[0];
			REG_BODY_MASS:   mass_q = data;
			REG_DRAG_FACTOR: drag_q = data[DRAG_W-1:0];
			REG_SPEED_LIMIT: limit_q = data[LIMIT_W-1:0];
			REG_START_X:     pos_q[0] = data;
			REG_START_Y:     pos_q[1] = data;
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			physics_on_q = 1'b0;
			drag_on_q = 1'b0;
			mass_q = MASS_RESET;
			drag_q = '0;
			limit_q = LIMIT_RESET;
			for (int axis = 0; axis < 2; axis++) begin
				pos_q[axis] = '0;
				vel_q[axis] = '0;
				force_sum[axis] = '0;
			end
			predicted_states.delete();
			beats_waiting <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				apply_setting(cfg_index, cfg_data);
			end
			// Results are matched before this edge's tick is predicted, so a result
			// can never be paired with the tick that arrives beside it.
			if (out_valid && out_ready) begin
				results_seen++;
				if (predicted_states.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with nothing predicted",
						results_seen));
				end else begin
					want = predicted_states.pop_front();
					check_field("pos_x", out_data.pos_x, want.pos_x);
					check_field("pos_y", out_data.pos_y, want.pos_y);
					check_field("vel_x", out_data.vel_x, want.vel_x);
					check_field("vel_y", out_data.vel_y, want.vel_y);
				end
			end
			if (in_valid && in_ready) begin
				apply_tick(in_data);
			end
			beats_waiting <= predicted_states.size();
		end
	end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

// Top of the Euler step bench. This module only makes stimulus and gives the verdict;
// the checker beside the block predicts every result beat and counts mismatches.
module testbench;
	import pebs_pkg::*;

	// Index 7 has no register behind it; a write there must change nothing.
	localparam logic [IDX_W-1:0]  REG_UNUSED = 3'd7;
	localparam logic [DATA_W-1:0] WORD_MAX   = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] WORD_MIN   = 32'h8000_0000;
	localparam logic [DT_W-1:0]   STEP_MAX   = 24'hFF_FFFF;
	// The receiver's one long hold, in cycles. It is far longer than one step takes.
	localparam int LONG_HOLD = 400;
	localparam int PHASES    = 15;
	// The tail covers a step with physics on, with room to spare.
	localparam int TAIL      = 41 + FRAC_BITS_DEF + 8;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	in_t               in_data;
	logic              out_valid;
	logic              out_ready;
	out_t              out_data;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index;
	logic [DATA_W-1:0] cfg_data;
	int                fail_count;
	int                beats_waiting;

	// Shared between the sender and the receiver: no_gaps turns off idling on both
	// sides for a whole phase, long_hold_due asks the receiver for one long stall.
	bit no_gaps = 1'b0;
	bit long_hold_due = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	planar_body_euler_step u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	euler_step_checker #(
		.FRAC_BITS (FRAC_BITS_DEF)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.beats_waiting (beats_waiting)
	);

	// Forces are mostly moderate so that the body actually moves without pinning at
	// the rails, with full-range words and the extremes mixed in.
	function automatic logic [DATA_W-1:0] random_force();
		logic [DATA_W-1:0] mag;
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
			2: return $urandom_range(0, 1) ? '0 : '1;
			default: begin
				mag = $urandom_range(0, 32'h0008_0000);
				return $urandom_range(0, 1) ? -mag : mag;
			end
		endcase
	endfunction

	// Time steps: frame-sized most of the time, sometimes the full 24-bit range.
	function automatic logic [DT_W-1:0] random_step();
		case ($urandom_range(0, 5))
			0: return DT_W'($urandom_range(0, STEP_MAX));
			1: return $urandom_range(0, 1) ? STEP_MAX : '0;
			2: return DT_W'($urandom_range(0, 24'h00_2000));
			default: return DT_W'($urandom_range(0, 24'h02_0000));
		endcase
	endfunction

	// Offer one tick beat after a random gap and hold it until it is accepted. When
	// the gap is zero, valid simply stays high and the next payload follows at once.
	task automatic tick(input logic [DATA_W-1:0] fx, input logic [DATA_W-1:0] fy,
			input logic [DT_W-1:0] dt);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data <= '{force_x: fx, force_y: fy, time_step: dt};
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Writes keep cfg_valid high from one to the next; the caller lowers it after the
	// last write of a batch.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// Stop offering ticks and wait until every predicted result has been taken. Every
	// tick yields a result, so a few cycles more are enough before the registers move.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (beats_waiting != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Receiver: a random stall before each result beat, and one long hold on request
	// during which the sender keeps offering ticks and the block backs up.
	initial begin
		int stall;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 7);
			if (long_hold_due) begin
				long_hold_due = 1'b0;
				stall = LONG_HOLD;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin
		int                 count;
		logic               phys;
		logic [MASS_W-1:0]  mass;
		logic [DRAG_W-1:0]  drag;
		logic [DATA_W-1:0]  limit;

		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Physics is off after reset: the extreme forces pile up in the pending sum,
		// which saturates on the second beat while the body stays at the origin.
		tick(WORD_MAX, WORD_MIN, STEP_MAX);
		tick(WORD_MAX, WORD_MIN, STEP_MAX);
		tick('0, '0, '0);
		wait_idle();

		// Physics on with unit mass: the saturated pending force drives the velocity
		// to the rails, the position saturates and the velocity is clamped to the cap.
		// A zero time step then leaves the velocity where it is.
		write_reg(REG_PHYSICS_ON, 32'd1);
		cfg_valid <= 1'b0;
		tick('0, '0, STEP_MAX);
		tick(32'h0001_0000, 32'hFFFF_0000, 24'h01_0000);
		tick('0, '0, '0);
		wait_idle();

		// Largest drag against the smallest mass, no effective speed cap, and the body
		// moved to opposite corners so that position saturates both ways.
		write_reg(REG_DRAG_ON, 32'd1);
		write_reg(REG_DRAG_FACTOR, 32'h00FF_FFFF);
		write_reg(REG_BODY_MASS, 32'd1);
		write_reg(REG_SPEED_LIMIT, WORD_MAX);
		write_reg(REG_START_X, WORD_MAX);
		write_reg(REG_START_Y, WORD_MIN);
		cfg_valid <= 1'b0;
		tick(32'd1, '1, 24'd1);
		tick(WORD_MAX, WORD_MIN, STEP_MAX);
		tick(WORD_MIN, WORD_MAX, 24'h00_8000);
		tick('0, '0, 24'h01_0000);
		wait_idle();

		// A zero mass counts as the smallest one, a zero cap pins the velocity at zero,
		// and a write to the unused index must be ignored.
		write_reg(REG_BODY_MASS, '0);
		write_reg(REG_SPEED_LIMIT, '0);
		write_reg(REG_DRAG_FACTOR, '0);
		write_reg(REG_UNUSED, '1);
		write_reg(REG_START_X, '0);
		write_reg(REG_START_Y, '0);
		cfg_valid <= 1'b0;
		tick(32'h0001_2345, 32'hFFFA_BCDF, 24'h00_0100);
		tick('1, 32'd1, STEP_MAX);
		wait_idle();

		// Heaviest mass: even the largest force barely moves the body.
		write_reg(REG_DRAG_ON, '0);
		write_reg(REG_BODY_MASS, '1);
		write_reg(REG_SPEED_LIMIT, 32'h0004_0000);
		write_reg(REG_DRAG_FACTOR, 32'h0000_8000);
		cfg_valid <= 1'b0;
		tick(WORD_MAX, WORD_MAX, STEP_MAX);
		tick(WORD_MAX, WORD_MAX, STEP_MAX);
		tick(WORD_MIN, '0, STEP_MAX);
		wait_idle();

		// Forces gathered while physics is off are spent by the next step, with drag.
		write_reg(REG_PHYSICS_ON, '0);
		write_reg(REG_BODY_MASS, 32'h0001_0000);
		cfg_valid <= 1'b0;
		tick(32'h0004_0000, 32'hFFFC_0000, 24'h00_1234);
		tick(32'h0004_0000, 32'hFFFC_0000, 24'h00_1234);
		wait_idle();
		write_reg(REG_PHYSICS_ON, 32'd1);
		write_reg(REG_DRAG_ON, 32'd1);
		cfg_valid <= 1'b0;
		tick('0, '0, 24'h00_8000);
		wait_idle();

		// Random phases. Each one starts from fresh settings, biased toward usual
		// values with the extremes mixed in. Every fourth phase only gathers forces so
		// that the phase after it starts with a pending sum. Upper data bits that a
		// register does not keep are filled at random.
		for (int p = 0; p < PHASES; p++) begin
			phys = (p % 4 != 1);
			no_gaps = (p % 5 == 3);
			if (p == 2) begin
				long_hold_due = 1'b1;
			end
			write_reg(REG_PHYSICS_ON, {31'($urandom), phys});
			write_reg(REG_DRAG_ON, $urandom);
			case ($urandom_range(0, 4))
				0: mass = 32'd1;
				1: mass = '1;
				2: mass = $urandom;
				default: mass = $urandom_range(32'h0000_4000, 32'h0004_0000);
			endcase
			write_reg(REG_BODY_MASS, mass);
			case ($urandom_range(0, 4))
				0: drag = '0;
				1: drag = '1;
				2: drag = DRAG_W'($urandom);
				default: drag = DRAG_W'($urandom_range(0, 24'h02_0000));
			endcase
			write_reg(REG_DRAG_FACTOR, {8'($urandom), drag});
			case ($urandom_range(0, 4))
				0: limit = {1'($urandom), 31'd0};
				1: limit = WORD_MAX;
				2: limit = $urandom;
				default: limit = $urandom_range(32'h0001_0000, 32'h0040_0000);
			endcase
			write_reg(REG_SPEED_LIMIT, limit);
			if ($urandom_range(0, 2) == 0) begin
				write_reg(REG_START_X, random_force());
				write_reg(REG_START_Y, random_force());
			end
			cfg_valid <= 1'b0;
			count = $urandom_range(80, 112);
			repeat (count) tick(random_force(), random_force(), random_step());
			wait_idle();
		end

		// Any result beyond the last prediction would show up within one step time.
		no_gaps = 1'b1;
		repeat (TAIL) @(posedge clk);
		if (fail_count == 0 && beats_waiting == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// A clean run takes about a millisecond of simulated time; this is several times
	// that.
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/pebs_pkg.sv
rtl/core/pebs_div.sv
rtl/core/pebs_lane.sv
rtl/core/planar_body_euler_step.sv
rtl/core/pebs_checker.sv
tb/euler_step_checker.sv
tb/testbench.sv
